// ===== hw/rtl/lis_pkg.sv =====
// lis_pkg: shared constants, microcode types and control program for the lis tracker
`default_nettype none

package lis_pkg;

  localparam int VALUE_COUNT = 1024;
  localparam int VALUE_W = 10;
  localparam int LEN_W = 11;
  localparam int LEAVES = 1 << $clog2(VALUE_COUNT);
  localparam int NODES = 2 * LEAVES;
  localparam int NODE_W = $clog2(NODES);
  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [VALUE_W-1:0] VALUE_TOP = VALUE_W'(VALUE_COUNT - 1);
  localparam logic [NODE_W-1:0] LEAF_BASE = NODE_W'(LEAVES);
  localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE = 3'd0;
  localparam step_t STEP_QUERY = 3'd1;
  localparam step_t STEP_CAND = 3'd2;
  localparam step_t STEP_UPDATE = 3'd3;
  localparam step_t STEP_EMIT = 3'd4;
  localparam step_t STEP_TAIL = 3'd5;
  localparam step_t STEP_CLEAR = 3'd6;
  localparam step_t STEP_DONE = 3'd7;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_NO_INPUT,
    JMP_NODE_UP,
    JMP_NODE_LIVE,
    JMP_OUT_BUSY,
    JMP_NOT_LAST,
    JMP_CLR_BUSY
  } jump_t;

  typedef struct packed {
    logic  in_rdy;
    logic  ld_item;
    logic  q_read;
    logic  cand_ld;
    logic  u_read;
    logic  emit;
    logic  clr_write;
    jump_t jump;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic node_up;
    logic node_live;
    logic out_busy;
    logic last_item;
    logic clr_busy;
  } status_t;

  function automatic ctrl_t rom(input step_t s);
    ctrl_t w;
    w = '0;
    w.jump = JMP_NEXT;
    w.target = STEP_IDLE;
    case (s)
      STEP_IDLE: begin
        w.in_rdy = 1'b1;
        w.ld_item = 1'b1;
        w.jump = JMP_NO_INPUT;
        w.target = STEP_IDLE;
      end
      STEP_QUERY: begin
        w.q_read = 1'b1;
        w.jump = JMP_NODE_UP;
        w.target = STEP_QUERY;
      end
      STEP_CAND: begin
        w.cand_ld = 1'b1;
      end
      STEP_UPDATE: begin
        w.u_read = 1'b1;
        w.jump = JMP_NODE_LIVE;
        w.target = STEP_UPDATE;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.jump = JMP_OUT_BUSY;
        w.target = STEP_EMIT;
      end
      STEP_TAIL: begin
        w.jump = JMP_NOT_LAST;
        w.target = STEP_IDLE;
      end
      STEP_CLEAR: begin
        w.clr_write = 1'b1;
        w.jump = JMP_CLR_BUSY;
        w.target = STEP_CLEAR;
      end
      default: begin
        w.jump = JMP_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lis_in_if.sv =====
// lis_in_if: input channel carrying one sequence element per transaction
`default_nettype none

interface lis_in_if;
  logic                          valid;
  logic                          ready;
  logic [lis_pkg::VALUE_W-1:0]   value;
  logic                          last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lis_out_if.sv =====
// lis_out_if: result channel carrying the best length per transaction
`default_nettype none

interface lis_out_if;
  logic                        valid;
  logic                        ready;
  logic [lis_pkg::LEN_W-1:0]   best_length;
  logic                        done_res;

  modport source (output valid, output best_length, output done_res, input ready);
  modport sink (input valid, input best_length, input done_res, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lis_seq.sv =====
// lis_seq: step counter, control store and conditional jumps
`default_nettype none

module lis_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire lis_pkg::status_t status,
  output lis_pkg::ctrl_t        ctrl
);

  lis_pkg::step_t step;
  lis_pkg::step_t step_next;
  logic           taken;

  assign ctrl = lis_pkg::rom(step);

  always_comb begin
    case (ctrl.jump)
      lis_pkg::JMP_NEXT:      taken = 1'b0;
      lis_pkg::JMP_ALWAYS:    taken = 1'b1;
      lis_pkg::JMP_NO_INPUT:  taken = !in_valid;
      lis_pkg::JMP_NODE_UP:   taken = status.node_up;
      lis_pkg::JMP_NODE_LIVE: taken = status.node_live;
      lis_pkg::JMP_OUT_BUSY:  taken = status.out_busy;
      lis_pkg::JMP_NOT_LAST:  taken = !status.last_item;
      lis_pkg::JMP_CLR_BUSY:  taken = status.clr_busy;
      default:                taken = 1'b0;
    endcase
  end

  always_comb begin
    step_next = taken ? ctrl.target : step + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= lis_pkg::STEP_CLEAR;
    end else begin
      step <= step_next;
    end
  end

`ifndef SYNTH
  a_clear_from_tail: assert property (@(posedge clk) disable iff (rst)
    (step == lis_pkg::STEP_CLEAR) |-> ($past(step) == lis_pkg::STEP_CLEAR
      || $past(step) == lis_pkg::STEP_TAIL))
    else $error("clear pass entered from an unexpected step");
  a_idle_after_accept: assert property (@(posedge clk) disable iff (rst)
    (step == lis_pkg::STEP_IDLE && in_valid) |=> (step == lis_pkg::STEP_QUERY))
    else $error("accepted transaction did not start the query walk");
  a_tail_after_emit: assert property (@(posedge clk) disable iff (rst)
    (step == lis_pkg::STEP_TAIL) |-> ($past(step) == lis_pkg::STEP_EMIT))
    else $error("tail step reached without a result");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lis_dp.sv =====
// lis_dp: tree memory, walk registers and result register
`default_nettype none

module lis_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lis_pkg::ctrl_t              ctrl,
  input  wire logic                        in_fire,
  input  wire logic [lis_pkg::VALUE_W-1:0] value,
  input  wire logic                        last,
  input  wire logic                        out_ready,
  output lis_pkg::status_t                 status,
  output logic                             out_valid,
  output logic [lis_pkg::LEN_W-1:0]        best_length,
  output logic                             done_res
);

  logic [lis_pkg::LEN_W-1:0]   tree [lis_pkg::NODES];

  logic [lis_pkg::NODE_W-1:0]  node;
  logic [lis_pkg::NODE_W-1:0]  leaf;
  logic [lis_pkg::NODE_W-1:0]  wa;
  logic [lis_pkg::NODE_W-1:0]  clr_addr;
  logic [lis_pkg::LEN_W-1:0]   acc;
  logic [lis_pkg::LEN_W-1:0]   acc_next;
  logic [lis_pkg::LEN_W-1:0]   cand;
  logic [lis_pkg::LEN_W-1:0]   cand_val;
  logic [lis_pkg::LEN_W-1:0]   best;
  logic [lis_pkg::LEN_W-1:0]   rdata;
  logic                        last_r;
  logic                        qv;
  logic                        uv;

  logic [lis_pkg::VALUE_W-1:0] vsat;
  logic [lis_pkg::NODE_W-1:0]  leaf_val;
  logic                        node_up;
  logic                        node_live;
  logic                        q_go;
  logic                        u_go;
  logic                        rd_en;
  logic [lis_pkg::NODE_W-1:0]  rd_addr;
  logic                        we;
  logic [lis_pkg::NODE_W-1:0]  waddr;
  logic [lis_pkg::LEN_W-1:0]   wdata;

  assign node_up = (node != lis_pkg::ROOT_NODE);
  assign node_live = (node != '0);
  assign q_go = ctrl.q_read && node_up;
  assign u_go = ctrl.u_read && node_live;

  always_comb begin
    vsat = (int'(value) >= lis_pkg::VALUE_COUNT) ? lis_pkg::VALUE_TOP : value;
    leaf_val = lis_pkg::LEAF_BASE + lis_pkg::NODE_W'(vsat);
  end

  always_comb begin
    acc_next = (qv && rdata > acc) ? rdata : acc;
    cand_val = (acc_next == lis_pkg::LEN_MAX) ? lis_pkg::LEN_MAX
                                               : acc_next + lis_pkg::LEN_W'(1);
  end

  // left sibling on the query walk, the path node itself on the update walk
  always_comb begin
    rd_en = q_go || u_go;
    rd_addr = q_go ? (node ^ lis_pkg::NODE_W'(1)) : node;
  end

  always_comb begin
    we = uv || ctrl.clr_write;
    waddr = ctrl.clr_write ? clr_addr : wa;
    wdata = ctrl.clr_write ? '0 : ((rdata > cand) ? rdata : cand);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= tree[rd_addr];
    end
    if (we) begin
      tree[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_item && in_fire) begin
      node <= leaf_val;
      leaf <= leaf_val;
      last_r <= last;
    end else if (q_go || u_go) begin
      node <= node >> 1;
    end else if (ctrl.cand_ld) begin
      node <= leaf;
    end
    acc <= ctrl.ld_item ? '0 : acc_next;
    if (ctrl.cand_ld) begin
      cand <= cand_val;
    end
    wa <= node;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= 1'b0;
      uv <= 1'b0;
      best <= '0;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      qv <= q_go && node[0];
      uv <= u_go;
      if (ctrl.clr_write) begin
        clr_addr <= clr_addr + lis_pkg::NODE_W'(1);
        best <= '0;
      end else if (ctrl.cand_ld && cand_val > best) begin
        best <= cand_val;
      end
      if (ctrl.emit && !out_valid) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && !out_valid) begin
      best_length <= best;
      done_res <= last_r;
    end
  end

  always_comb begin
    status.node_up = node_up;
    status.node_live = node_live;
    status.out_busy = out_valid;
    status.last_item = last_r;
    status.clr_busy = (clr_addr != '1);
  end

`ifndef SYNTH
  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    uv |-> !ctrl.clr_write)
    else $error("update write and clear write in the same cycle");
  a_cand_nonzero: assert property (@(posedge clk) disable iff (rst)
    $past(ctrl.cand_ld) |-> (cand != '0))
    else $error("candidate length is zero");
  a_best_covers_cand: assert property (@(posedge clk) disable iff (rst)
    $past(ctrl.cand_ld) |-> (best >= cand))
    else $error("running best below candidate");
  a_no_node_zero: assert property (@(posedge clk) disable iff (rst)
    uv |-> (wa != '0))
    else $error("update walk wrote the unused node");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/longest_increasing_subsequence.sv =====
// longest_increasing_subsequence: top level, microcoded tree walker for lis length
//
//   channel  | dir | payload                      | transaction
//   in_item  | in  | value[9:0], last             | valid && ready
//   out_res  | out | best_length[10:0], done_res  | valid && ready
//
// each item runs from one acceptance to the next through one accept step, an
// 11-step prefix walk and a 12-step update walk over the single tree memory,
// plus candidate, emit and tail steps; one read and one write port keep the walks serial
// the result register turns valid as the sequencer moves from emit to the tail step
// a result waits in an output register; the sequencer stalls at emit while it is full
// after reset and after an item marked last, a clear pass sweeps the whole tree
// reset is synchronous and active high; no item is accepted during the clear pass
`default_nettype none

module longest_increasing_subsequence (
  input  wire logic clk,
  input  wire logic rst,
  lis_in_if.sink    in_item,
  lis_out_if.source out_res
);

  lis_pkg::ctrl_t   ctrl;
  lis_pkg::status_t status;
  logic             in_fire;

  assign in_item.ready = ctrl.in_rdy;
  assign in_fire = in_item.valid && ctrl.in_rdy;

  lis_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_item.valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  lis_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .in_fire     (in_fire),
    .value       (in_item.value),
    .last        (in_item.last),
    .out_ready   (out_res.ready),
    .status      (status),
    .out_valid   (out_res.valid),
    .best_length (out_res.best_length),
    .done_res    (out_res.done_res)
  );

endmodule

`default_nettype wire

// ===== tb/sv/lis_check_pkg.sv =====
// lis_check_pkg: expected-length tracker and result checker for the lis testbench
package lis_check_pkg;
  import lis_pkg::*;

  typedef struct packed {
    logic [LEN_W-1:0] best_length;
    logic             done_res;
  } lis_result_t;

  class lis_length_check;
    logic [LEN_W-1:0] len_at [VALUE_COUNT];
    logic [LEN_W-1:0] seq_best;
    lis_result_t      pending_lengths [$];
    int unsigned      mismatches;
    int unsigned      results_seen;
    int unsigned      longest_seen;

    function new();
      mismatches = 0;
      results_seen = 0;
      longest_seen = 0;
      clear_sequence();
    endfunction

    function void clear_sequence();
      foreach (len_at[i]) len_at[i] = '0;
      seq_best = '0;
    endfunction

    // length of the longest strictly increasing run ending in value, plus running best
    function void note_element(logic [VALUE_W-1:0] value, logic last);
      logic [VALUE_W-1:0] v;
      logic [LEN_W-1:0]   below;
      logic [LEN_W-1:0]   cand;
      lis_result_t        r;
      v = (value > VALUE_TOP) ? VALUE_TOP : value;
      below = '0;
      for (int i = 0; i < int'(v); i++) begin
        if (len_at[i] > below) below = len_at[i];
      end
      cand = (below == LEN_MAX) ? LEN_MAX : below + 1'b1;
      if (cand > len_at[v]) len_at[v] = cand;
      if (cand > seq_best) seq_best = cand;
      r.best_length = seq_best;
      r.done_res = last;
      pending_lengths.push_back(r);
      if (last) clear_sequence();
    endfunction

    function void check_length(logic [LEN_W-1:0] best_length, logic done_res);
      lis_result_t e;
      results_seen++;
      if (best_length > longest_seen) longest_seen = 32'(best_length);
      if (pending_lengths.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction best_length=%0d done_res=%0b",
                 $time, best_length, done_res);
        return;
      end
      e = pending_lengths.pop_front();
      if (best_length !== e.best_length) begin
        mismatches++;
        $display("%0t: best_length expected %0d actual %0d",
                 $time, e.best_length, best_length);
      end
      if (done_res !== e.done_res) begin
        mismatches++;
        $display("%0t: done_res expected %0b actual %0b", $time, e.done_res, done_res);
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_longest_increasing_subsequence.sv =====
// tb_longest_increasing_subsequence: random and directed sequences checked against a predicted lis length
module tb_longest_increasing_subsequence;
  timeunit 1ns;
  timeprecision 1ps;

  import lis_pkg::*;
  import lis_check_pkg::*;

  localparam int unsigned ITEM_TARGET = 1750;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } lis_element_t;

  typedef enum int {
    SHAPE_UNIFORM,
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_NARROW
  } seq_shape_t;

  logic clk;
  logic rst;

  lis_in_if  in_item ();
  lis_out_if out_res ();

  longest_increasing_subsequence dut (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_item),
    .out_res (out_res)
  );

  lis_length_check book;
  lis_element_t    stimulus [$];
  int unsigned     cycle_count;
  int unsigned     elements_sent;
  int unsigned     sequences_sent;
  int unsigned     failures;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL");
    $finish;
  end

  function automatic void add_element(int v, bit last);
    lis_element_t e;
    e.value = VALUE_W'(v);
    e.last = last;
    stimulus.push_back(e);
  endfunction

  function automatic int clip_value(int v);
    if (v < 0) return 0;
    if (v > int'(VALUE_TOP)) return int'(VALUE_TOP);
    return v;
  endfunction

  task automatic build_stimulus();
    seq_shape_t shape;
    int         seq_len;
    int         v;
    int         base;
    // single-element sequences at both ends of the range
    add_element(0, 1'b1);
    add_element(1023, 1'b1);
    // strictly rising through the extremes
    add_element(0, 1'b0);
    add_element(1, 1'b0);
    add_element(2, 1'b0);
    add_element(1023, 1'b1);
    // falling pair
    add_element(1023, 1'b0);
    add_element(0, 1'b1);
    // repeated values do not extend the run
    add_element(5, 1'b0);
    add_element(5, 1'b0);
    add_element(5, 1'b1);
    // mixed order
    add_element(512, 1'b0);
    add_element(256, 1'b0);
    add_element(768, 1'b0);
    add_element(100, 1'b0);
    add_element(300, 1'b0);
    add_element(900, 1'b1);
    // alternating bit patterns
    add_element(10'h155, 1'b0);
    add_element(10'h2aa, 1'b0);
    add_element(10'h3ff, 1'b0);
    add_element(10'h000, 1'b1);
    // full rising sweep reaches the longest possible run
    for (int i = 0; i < VALUE_COUNT; i++) add_element(i, i == VALUE_COUNT - 1);
    while (stimulus.size() < ITEM_TARGET) begin
      shape = seq_shape_t'($urandom_range(0, 3));
      seq_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 80);
      base = $urandom_range(0, 1023);
      v = base;
      for (int k = 0; k < seq_len; k++) begin
        case (shape)
          SHAPE_UNIFORM: begin
            v = $urandom_range(0, 1023);
          end
          SHAPE_RISING: begin
            if (k == 0) v = $urandom_range(0, 200);
            else if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 1023);
            else v = clip_value(v + $urandom_range(0, 20));
          end
          SHAPE_FALLING: begin
            if (k == 0) v = $urandom_range(823, 1023);
            else if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 1023);
            else v = clip_value(v - $urandom_range(0, 20));
          end
          default: begin
            v = clip_value(base + $urandom_range(0, 7));
          end
        endcase
        add_element(v, k == seq_len - 1);
      end
    end
  endtask

  task automatic drive_elements();
    lis_element_t e;
    int unsigned  gap;
    bit           burst;
    burst = 1'b0;
    while (stimulus.size() != 0) begin
      e = stimulus.pop_front();
      if ($urandom_range(0, 15) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        in_item.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_item.valid <= 1'b1;
      in_item.value <= e.value;
      in_item.last <= e.last;
      do @(posedge clk); while (!in_item.ready);
      book.note_element(e.value, e.last);
      elements_sent++;
      if (e.last) sequences_sent++;
    end
    in_item.valid <= 1'b0;
  endtask

  task automatic collect_results();
    int unsigned stall;
    bit          burst;
    burst = 1'b0;
    forever begin
      if ($urandom_range(0, 15) == 0) burst = !burst;
      stall = burst ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_res.ready <= 1'b1;
      do @(posedge clk); while (!out_res.valid);
      book.check_length(out_res.best_length, out_res.done_res);
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_item.valid <= 1'b0;
    in_item.value <= '0;
    in_item.last <= 1'b0;
    out_res.ready <= 1'b0;
    book = new();
    elements_sent = 0;
    sequences_sent = 0;
    build_stimulus();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    fork
      collect_results();
    join_none
    drive_elements();
    while (book.pending_lengths.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    failures = book.mismatches + book.pending_lengths.size();
    $display("%0d elements in %0d sequences sent, %0d results compared",
             elements_sent, sequences_sent, book.results_seen);
    $display("longest increasing run reported: %0d, mismatches: %0d",
             book.longest_seen, failures);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
